FILE: hw/rtl/gti_pkg.sv
package gti_pkg;

	localparam int GRID_DEPTH = 65536;
	localparam int FRAC_BITS  = 10;

	localparam int ADDR_W    = $clog2(GRID_DEPTH);
	localparam int COORD_W   = 16;
	localparam int VAL_W     = 32;
	localparam int SIZE_W    = 7;
	localparam int CFG_IDX_W = 2;

	localparam int IP_W   = (COORD_W > FRAC_BITS) ? COORD_W - FRAC_BITS : 1;
	localparam int W_W    = FRAC_BITS + 1;
	localparam int WXY_W  = 2 * W_W;
	localparam int WT_W   = 3 * FRAC_BITS + 1;
	localparam int SUM_S  = 3 * FRAC_BITS;
	localparam int ACC_W  = 3 * FRAC_BITS + 34;
	localparam int BASE_W = (IP_W + 16 > ADDR_W + 1) ? IP_W + 16 : ADDR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_X_RST = 7'd64;
	localparam logic [SIZE_W-1:0] SIZE_Y_RST = 7'd64;
	localparam logic [SIZE_W-1:0] SIZE_Z_RST = 7'd16;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_INTERP = 1'b1;

	typedef struct packed {
		logic                      command;
		logic [COORD_W-1:0]        grid_address;
		logic signed [VAL_W-1:0]   grid_value;
		logic [COORD_W-1:0]        coord_x;
		logic [COORD_W-1:0]        coord_y;
		logic [COORD_W-1:0]        coord_z;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]   interpolated_value;
		logic                      out_of_range;
	} rsp_t;

endpackage

FILE: hw/rtl/grid_trilinear_interpolator.sv
// Trilinear interpolation over a grid of signed Q16.16 values held in one
// single-ported memory.
// Request channel: an item is taken at a rising edge with start high and
// busy low. A write request (command write) stores grid_value at
// grid_address in that same edge and leaves busy low, so writes stream at
// one per cycle; addresses beyond the grid memory are dropped. An
// interpolate request raises busy until its result has been formed.
// Result channel: done is high for exactly one cycle with result valid;
// there is no back-pressure, the receiver must take it then.
// Sequence: an in-range interpolation passes the setup states SPLIT, BASE
// and CHECK (corner address and range check), eight corner reads through
// the one memory port, then the weight and product pipeline and DRAIN; an
// out-of-range point returns done from CHECK. Interpolations do not
// overlap; each is bounded by the eight serial corner reads plus setup and
// drain. Busy drops in the cycle done rises, so the next request can be
// taken in that cycle. Configuration: cfg_we writes size_x, size_y, size_z
// by index; the user must assert it only while idle, the block does not
// enforce it. Reset sets sizes to 64, 64, 16 and idles the control; the
// grid memory is not cleared, an entry must be written before it is read.
module grid_trilinear_interpolator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gti_pkg::SIZE_W-1:0]        cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  gti_pkg::req_t                     request,
	output logic                              done,
	output gti_pkg::rsp_t                     result
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SPLIT = 3'd1;
	localparam logic [2:0] ST_BASE  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	logic [2:0] state_q;
	logic [gti_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

	logic [gti_pkg::COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [gti_pkg::IP_W-1:0]    ipx, ipy, ipz;
	logic [gti_pkg::IP_W-1:0]    ipx_q, ipz_q;
	logic [gti_pkg::W_W-1:0]     wx_q [2];
	logic [gti_pkg::W_W-1:0]     wy_q [2];
	logic [gti_pkg::W_W-1:0]     wz_q [2];
	logic [2*gti_pkg::SIZE_W-1:0] sxy_q;
	logic [gti_pkg::IP_W+gti_pkg::SIZE_W-1:0] ysx_q;
	logic [gti_pkg::IP_W+2*gti_pkg::SIZE_W-1:0] zsxy;
	logic bad_q, range_bad, far_bad;
	logic [gti_pkg::BASE_W-1:0] base_q, far, corner;
	logic [2:0] k_q;

	logic accept, in_depth, ram_we;
	logic [gti_pkg::ADDR_W-1:0] ram_addr;
	logic [gti_pkg::VAL_W-1:0]  ram_rdata;

	logic v_s1, v_s2, v_s3, last_s1, last_s2, last_s3, fin_q;
	logic [gti_pkg::WXY_W-1:0] wxy_full, wxy_s1;
	logic [gti_pkg::W_W-1:0]   wz_s1;
	logic [gti_pkg::WXY_W+gti_pkg::W_W-1:0] wt_full;
	logic [gti_pkg::WT_W-1:0]  wt_s2;
	logic [gti_pkg::VAL_W-1:0] val_s2;
	logic signed [gti_pkg::WT_W+16:0] phi_full, phi_s3;
	logic [gti_pkg::WT_W+15:0] plo_full, plo_s3;
	logic [gti_pkg::ACC_W-1:0] acc_q, rnd;

	logic done_q;
	gti_pkg::rsp_t result_q;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	assign in_depth = (gti_pkg::BASE_W'(request.grid_address) <
		gti_pkg::BASE_W'(gti_pkg::GRID_DEPTH));
	assign ram_we   = accept && (request.command == gti_pkg::CMD_WRITE) && in_depth;

	assign ipx = gti_pkg::IP_W'(cx_q >> gti_pkg::FRAC_BITS);
	assign ipy = gti_pkg::IP_W'(cy_q >> gti_pkg::FRAC_BITS);
	assign ipz = gti_pkg::IP_W'(cz_q >> gti_pkg::FRAC_BITS);

	assign range_bad =
		(gti_pkg::BASE_W'(ipx) + gti_pkg::BASE_W'(1) >= gti_pkg::BASE_W'(size_x_q)) ||
		(gti_pkg::BASE_W'(ipy) + gti_pkg::BASE_W'(1) >= gti_pkg::BASE_W'(size_y_q)) ||
		(gti_pkg::BASE_W'(ipz) + gti_pkg::BASE_W'(1) >= gti_pkg::BASE_W'(size_z_q));

	assign zsxy = ipz_q * sxy_q;
	assign far  = base_q + gti_pkg::BASE_W'(1) + gti_pkg::BASE_W'(size_x_q) +
		gti_pkg::BASE_W'(sxy_q);
	assign far_bad = (far >= gti_pkg::BASE_W'(gti_pkg::GRID_DEPTH));

	assign corner = base_q + gti_pkg::BASE_W'(k_q[0]) +
		(k_q[1] ? gti_pkg::BASE_W'(size_x_q) : '0) +
		(k_q[2] ? gti_pkg::BASE_W'(sxy_q) : '0);

	assign ram_addr = (state_q == ST_READ) ? gti_pkg::ADDR_W'(corner) :
		gti_pkg::ADDR_W'(gti_pkg::BASE_W'(request.grid_address));

	assign wxy_full = wx_q[k_q[0]] * wy_q[k_q[1]];
	assign wt_full  = wxy_s1 * wz_s1;
	assign phi_full = $signed({1'b0, wt_s2}) * $signed(val_s2[31:16]);
	assign plo_full = wt_s2 * val_s2[15:0];
	assign rnd      = acc_q + (gti_pkg::ACC_W'(1) << (gti_pkg::SUM_S - 1));

	gti_ram #(
		.WIDTH(gti_pkg::VAL_W),
		.DEPTH(gti_pkg::GRID_DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(request.grid_value),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= gti_pkg::SIZE_X_RST;
			size_y_q <= gti_pkg::SIZE_Y_RST;
			size_z_q <= gti_pkg::SIZE_Z_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gti_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				gti_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				gti_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
			fin_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_READ);
			last_s1 <= (state_q == ST_READ) && (k_q == 3'd7);
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			fin_q   <= v_s3 && last_s3;
			done_q  <= ((state_q == ST_CHECK) && (bad_q || far_bad)) ||
				((state_q == ST_DRAIN) && fin_q);
			case (state_q)
				ST_IDLE: begin
					if (accept && request.command == gti_pkg::CMD_INTERP) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: state_q <= ST_BASE;
				ST_BASE:  state_q <= ST_CHECK;
				ST_CHECK: begin
					k_q <= '0;
					if (bad_q || far_bad) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= request.coord_x;
			cy_q <= request.coord_y;
			cz_q <= request.coord_z;
		end
		if (state_q == ST_SPLIT) begin
			ipx_q    <= ipx;
			ipz_q    <= ipz;
			wx_q[1]  <= gti_pkg::W_W'(cx_q[gti_pkg::FRAC_BITS-1:0]);
			wy_q[1]  <= gti_pkg::W_W'(cy_q[gti_pkg::FRAC_BITS-1:0]);
			wz_q[1]  <= gti_pkg::W_W'(cz_q[gti_pkg::FRAC_BITS-1:0]);
			wx_q[0]  <= (gti_pkg::W_W'(1) << gti_pkg::FRAC_BITS) -
				gti_pkg::W_W'(cx_q[gti_pkg::FRAC_BITS-1:0]);
			wy_q[0]  <= (gti_pkg::W_W'(1) << gti_pkg::FRAC_BITS) -
				gti_pkg::W_W'(cy_q[gti_pkg::FRAC_BITS-1:0]);
			wz_q[0]  <= (gti_pkg::W_W'(1) << gti_pkg::FRAC_BITS) -
				gti_pkg::W_W'(cz_q[gti_pkg::FRAC_BITS-1:0]);
			sxy_q    <= size_x_q * size_y_q;
			ysx_q    <= ipy * size_x_q;
			bad_q    <= range_bad;
		end
		if (state_q == ST_BASE) begin
			base_q <= gti_pkg::BASE_W'(ipx_q) + gti_pkg::BASE_W'(ysx_q) +
				gti_pkg::BASE_W'(zsxy);
		end
		if (state_q == ST_CHECK) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + (gti_pkg::ACC_W'(phi_s3) << 16) + gti_pkg::ACC_W'(plo_s3);
		end
		wxy_s1 <= wxy_full;
		wz_s1  <= wz_q[k_q[2]];
		wt_s2  <= wt_full[gti_pkg::WT_W-1:0];
		val_s2 <= ram_rdata;
		phi_s3 <= phi_full;
		plo_s3 <= plo_full;
		if (state_q == ST_CHECK) begin
			result_q.interpolated_value <= '0;
			result_q.out_of_range       <= 1'b1;
		end else if (fin_q) begin
			result_q.interpolated_value <= rnd[gti_pkg::SUM_S +: gti_pkg::VAL_W];
			result_q.out_of_range       <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !busy)
		else $error("grid write while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a pending request");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_of_range) |-> (result.interpolated_value == '0))
		else $error("out-of-range result not zero");

	a_read_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_READ))
		else $error("corner read outside read sequence");

	a_interp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.command == gti_pkg::CMD_INTERP) |=> busy)
		else $error("interpolate request did not raise busy");
`endif

endmodule

FILE: hw/rtl/gti_ram.sv
module gti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: dv/gti_result_checker.sv
module gti_result_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gti_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gti_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          start,
	input  logic                          busy,
	input  gti_pkg::req_t                 request,
	input  logic                          done,
	input  gti_pkg::rsp_t                 result,
	output int                            mismatches,
	output int                            samples_due
);

	localparam int unsigned ONE = 1 << gti_pkg::FRAC_BITS;

	logic [gti_pkg::VAL_W-1:0]  grid_copy [gti_pkg::GRID_DEPTH];
	logic [gti_pkg::SIZE_W-1:0] span_x = gti_pkg::SIZE_X_RST;
	logic [gti_pkg::SIZE_W-1:0] span_y = gti_pkg::SIZE_Y_RST;
	logic [gti_pkg::SIZE_W-1:0] span_z = gti_pkg::SIZE_Z_RST;
	gti_pkg::rsp_t              sample_q [$];
	int                         fails = 0;

	assign mismatches = fails;

	task automatic report(input string msg);
		$display("%0t checker: %s", $time, msg);
		fails++;
	endtask

	function automatic gti_pkg::rsp_t interpolate_point(input gti_pkg::req_t r);
		int unsigned   sx, sy, sz, sxy, ix, iy, iz, fx, fy, fz, wx, wy, wz, base, addr;
		longint        acc, wt;
		gti_pkg::rsp_t p;
		sx  = 32'(span_x);
		sy  = 32'(span_y);
		sz  = 32'(span_z);
		sxy = sx * sy;
		ix  = 32'(r.coord_x >> gti_pkg::FRAC_BITS);
		iy  = 32'(r.coord_y >> gti_pkg::FRAC_BITS);
		iz  = 32'(r.coord_z >> gti_pkg::FRAC_BITS);
		fx  = 32'(r.coord_x) % ONE;
		fy  = 32'(r.coord_y) % ONE;
		fz  = 32'(r.coord_z) % ONE;
		base = ix + iy * sx + iz * sxy;
		p = '0;
		if (ix + 1 >= sx || iy + 1 >= sy || iz + 1 >= sz ||
				base + 1 + sx + sxy >= gti_pkg::GRID_DEPTH) begin
			p.out_of_range = 1'b1;
			return p;
		end
		acc = 0;
		for (int k = 0; k < 8; k++) begin
			wx   = k[0] ? fx : ONE - fx;
			wy   = k[1] ? fy : ONE - fy;
			wz   = k[2] ? fz : ONE - fz;
			addr = base + k[0] + k[1] * sx + k[2] * sxy;
			wt   = wx * wy * wz;
			acc  = acc + wt * longint'(signed'(grid_copy[addr]));
		end
		// round half up: floor of sum plus half
		acc = (acc + (longint'(1) << (gti_pkg::SUM_S - 1))) >>> gti_pkg::SUM_S;
		p.interpolated_value = acc[gti_pkg::VAL_W-1:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gti_pkg::rsp_t want;
		if (!arst_n) begin
			span_x = gti_pkg::SIZE_X_RST;
			span_y = gti_pkg::SIZE_Y_RST;
			span_z = gti_pkg::SIZE_Z_RST;
			sample_q.delete();
			samples_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					gti_pkg::REG_SIZE_X: span_x = cfg_data;
					gti_pkg::REG_SIZE_Y: span_y = cfg_data;
					gti_pkg::REG_SIZE_Z: span_z = cfg_data;
					default: ;
				endcase
			end
			if (done) begin
				if (sample_q.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = sample_q.pop_front();
					if (result.interpolated_value !== want.interpolated_value)
						report($sformatf("interpolated_value got %h want %h",
							result.interpolated_value, want.interpolated_value));
					if (result.out_of_range !== want.out_of_range)
						report($sformatf("out_of_range got %b want %b",
							result.out_of_range, want.out_of_range));
				end
			end
			if (start && !busy) begin
				if (request.command == gti_pkg::CMD_WRITE)
					grid_copy[request.grid_address] = request.grid_value;
				else
					sample_q.push_back(interpolate_point(request));
			end
			samples_due <= sample_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
module tb_top;

	localparam int          CYCLE_LIMIT = 200000;
	localparam int          SETTLE      = 24;
	localparam int unsigned ONE         = 1 << gti_pkg::FRAC_BITS;
	localparam int unsigned IP_TOP      = (1 << gti_pkg::IP_W) - 1;
	localparam logic [gti_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [gti_pkg::VAL_W-1:0] VAL_MAX = {1'b0, {(gti_pkg::VAL_W-1){1'b1}}};
	localparam logic [gti_pkg::VAL_W-1:0] VAL_MIN = {1'b1, {(gti_pkg::VAL_W-1){1'b0}}};

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          cfg_we    = 1'b0;
	logic [gti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [gti_pkg::SIZE_W-1:0]    cfg_data  = '0;
	logic                          start     = 1'b0;
	logic                          busy;
	gti_pkg::req_t                 request   = '0;
	logic                          done;
	gti_pkg::rsp_t                 result;
	int                            mismatches;
	int                            samples_due;

	int          cycles   = 0;
	int          sent     = 0;
	int          gap_next = 0;
	bit          steady   = 1'b0;
	bit          written [gti_pkg::GRID_DEPTH];
	int unsigned nx       = 32'(gti_pkg::SIZE_X_RST);
	int unsigned ny       = 32'(gti_pkg::SIZE_Y_RST);
	int unsigned nz       = 32'(gti_pkg::SIZE_Z_RST);

	grid_trilinear_interpolator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result)
	);

	gti_result_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.mismatches  (mismatches),
		.samples_due (samples_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [gti_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [gti_pkg::COORD_W-1:0] pick_coord(input int unsigned n);
		int unsigned ip_max, ip, frac;
		if (n < 2)
			return gti_pkg::COORD_W'($urandom);
		ip_max = (n - 2 > IP_TOP) ? IP_TOP : n - 2;
		ip = $urandom_range(0, ip_max);
		case ($urandom_range(0, 3))
			0: frac = 0;
			1: frac = ONE - 1;
			default: frac = $urandom_range(0, ONE - 1);
		endcase
		return gti_pkg::COORD_W'((ip << gti_pkg::FRAC_BITS) | frac);
	endfunction

	function automatic gti_pkg::req_t random_req();
		gti_pkg::req_t r;
		r.command      = 1'($urandom);
		r.grid_address = gti_pkg::COORD_W'($urandom);
		r.grid_value   = pick_value();
		r.coord_x      = gti_pkg::COORD_W'($urandom);
		r.coord_y      = gti_pkg::COORD_W'($urandom);
		r.coord_z      = gti_pkg::COORD_W'($urandom);
		return r;
	endfunction

	// start stays high across back-to-back requests
	task automatic put_request(input gti_pkg::req_t r);
		repeat (gap_next) @(posedge clk);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		sent++;
		gap_next = steady ? 0 : $urandom_range(0, 5);
		if (gap_next != 0)
			start <= 1'b0;
	endtask

	task automatic drop_start();
		if (gap_next == 0) begin
			start    <= 1'b0;
			gap_next = 1;
		end
	endtask

	task automatic put_write(input int unsigned addr,
			input logic [gti_pkg::VAL_W-1:0] v);
		gti_pkg::req_t r;
		r = random_req();
		r.command      = gti_pkg::CMD_WRITE;
		r.grid_address = gti_pkg::COORD_W'(addr);
		r.grid_value   = v;
		written[addr]  = 1'b1;
		put_request(r);
	endtask

	// fill any unwritten corner of an in-range point (with refresh, rewrite some at random) before it is interpolated
	task automatic put_point(input logic [gti_pkg::COORD_W-1:0] cx, cy, cz,
			input bit refresh);
		int unsigned   ix, iy, iz, sxy, base, a;
		gti_pkg::req_t r;
		ix   = 32'(cx >> gti_pkg::FRAC_BITS);
		iy   = 32'(cy >> gti_pkg::FRAC_BITS);
		iz   = 32'(cz >> gti_pkg::FRAC_BITS);
		sxy  = nx * ny;
		base = ix + iy * nx + iz * sxy;
		if (ix + 1 < nx && iy + 1 < ny && iz + 1 < nz &&
				base + 1 + nx + sxy < gti_pkg::GRID_DEPTH) begin
			for (int k = 0; k < 8; k++) begin
				a = base + k[0] + k[1] * nx + k[2] * sxy;
				if (!written[a] || (refresh && $urandom_range(0, 3) == 0))
					put_write(a, pick_value());
			end
		end
		r = random_req();
		r.command = gti_pkg::CMD_INTERP;
		r.coord_x = cx;
		r.coord_y = cy;
		r.coord_z = cz;
		put_request(r);
	endtask

	task automatic wait_idle();
		drop_start();
		@(posedge clk);
		while (samples_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_grid(input int unsigned sx, sy, sz);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= gti_pkg::REG_SIZE_X;
		cfg_data  <= sx[gti_pkg::SIZE_W-1:0];
		@(posedge clk);
		cfg_index <= gti_pkg::REG_SIZE_Y;
		cfg_data  <= sy[gti_pkg::SIZE_W-1:0];
		@(posedge clk);
		cfg_index <= gti_pkg::REG_SIZE_Z;
		cfg_data  <= sz[gti_pkg::SIZE_W-1:0];
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data  <= gti_pkg::SIZE_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		nx = 32'(sx[gti_pkg::SIZE_W-1:0]);
		ny = 32'(sy[gti_pkg::SIZE_W-1:0]);
		nz = 32'(sz[gti_pkg::SIZE_W-1:0]);
	endtask

	task automatic run_phase(input int quota);
		int stop_at;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			case ($urandom_range(0, 9))
				0: put_write($urandom_range(0, gti_pkg::GRID_DEPTH - 1), pick_value());
				1: put_point(gti_pkg::COORD_W'($urandom), gti_pkg::COORD_W'($urandom),
					gti_pkg::COORD_W'($urandom), 1'b1);
				default: put_point(pick_coord(nx), pick_coord(ny), pick_coord(nz), 1'b1);
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < 8; k++)
			put_write(k[0] + k[1] * nx + k[2] * nx * ny, (k % 3 == 0) ? VAL_MAX : VAL_MIN);
		put_point('0, '0, '0, 1'b0);
		put_point({6'd0, 10'd512}, {6'd0, 10'd512}, {6'd0, 10'd512}, 1'b0);
		// exact half between two corners, both signs
		put_write(0, '0);
		put_write(1, 32'd1);
		put_point({6'd0, 10'd512}, '0, '0, 1'b0);
		put_write(1, '1);
		put_point({6'd0, 10'd512}, '0, '0, 1'b0);
		// far corner just off each axis, then the last cell inside
		put_point({6'd63, 10'd0}, '0, '0, 1'b0);
		put_point('0, {6'd63, 10'd0}, '0, 1'b0);
		put_point('0, '0, {6'd15, 10'd0}, 1'b0);
		put_point({6'd62, 10'h3FF}, {6'd62, 10'h3FF}, {6'd14, 10'h3FF}, 1'b0);

		run_phase(130);
		set_grid(2, 2, 2);
		run_phase(120);
		set_grid(64, 64, 64);
		run_phase(130);
		set_grid(5, 3, 7);
		run_phase(110);
		set_grid(127, 127, 127);
		run_phase(90);
		set_grid(1, 0, 9);
		run_phase(30);
		repeat (3) begin
			set_grid($urandom_range(2, 64), $urandom_range(2, 64), $urandom_range(2, 64));
			run_phase(80);
		end

		wait_idle();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
